### rtl/lrl_pkg.sv
// Shared types and constants for the LRU recency list unit.
// No dependencies; imported by every module of the block.
package lrl_pkg;

   localparam int ENTRY_W     = 8;              // slot number width on the ports
   localparam int TOTAL_W     = 9;              // count width on the ports
   localparam int SLOT_SPAN   = 2 ** ENTRY_W;   // slots a request can name
   localparam int LRL_ENTRIES = 256;            // default table size

   typedef enum logic [2:0] {
      ACT_PUSH_HEAD = 3'd0,
      ACT_PUSH_TAIL = 3'd1,
      ACT_POP_TAIL  = 3'd2,
      ACT_UNLINK    = 3'd3,
      ACT_MOVE_HEAD = 3'd4
   } action_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_READ  = 6'b000100,
      S_MLINK = 6'b001000,
      S_LINK2 = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic               ok;
      logic [ENTRY_W-1:0] popped;
      logic [ENTRY_W-1:0] head;
      logic [ENTRY_W-1:0] tail;
      logic [TOTAL_W-1:0] total;
   } result_type;

endpackage

### rtl/lru_recency_list_unit.sv
// Top level of the LRU recency list unit: sequencer, two link memories,
// response register. Depends on lrl_pkg, lrl_seq and lrl_link_ram.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  req_    | in        | req_valid/req_stall  | action, entry_index
//  rsp_    | out       | rsp_valid/rsp_stall  | ok, popped_entry, head_entry,
//          |           |                      | tail_entry, entry_total, is_empty
//
// One request at a time. An accepted request passes through EXEC and then DONE;
// a push into a nonempty list adds LINK2, a pop or unlink on a longer list
// adds READ, and a move to head on a longer list adds READ, MLINK and LINK2.
// These steps are set by the single port on each link memory:
// a remove reads the slot's links then rewrites its neighbors, and a relink
// needs two writes per memory.
// Synchronous active-high reset clears head, tail, count and the linked flags
// at once; link memories are not cleared (links are read only for linked slots).
// The response sits in an output register; a new request is taken while it
// waits, and that request's result holds in the sequencer until the register
// frees up.
module lru_recency_list_unit
   import lrl_pkg::*;
#(
   parameter int ENTRIES = LRL_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic [ENTRY_W-1:0] req_entry_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [ENTRY_W-1:0] rsp_popped_entry,
   output logic [ENTRY_W-1:0] rsp_head_entry,
   output logic [ENTRY_W-1:0] rsp_tail_entry,
   output logic [TOTAL_W-1:0] rsp_entry_total,
   output logic               rsp_is_empty
);

   // A request can only name slots below SLOT_SPAN, so slots past that
   // would never be linked: table depth is capped there.
   localparam int SLOTS = (ENTRIES < SLOT_SPAN) ? ENTRIES : SLOT_SPAN;
   localparam int IDX_W = $clog2(SLOTS);

   logic             nx_en, nx_we, pv_en, pv_we;
   logic [IDX_W-1:0] nx_addr, nx_wdata, nx_rdata;
   logic [IDX_W-1:0] pv_addr, pv_wdata, pv_rdata;
   logic             done;
   logic             rsp_free;
   result_type       result;

   logic             rsp_valid_ff;
   result_type       rsp_ff;
   logic             empty_ff;

   // response slot can take a new result when empty or being drained now
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   lrl_seq #(
      .SLOTS (SLOTS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .rsp_free        (rsp_free),
      .done            (done),
      .result          (result),
      .nx_en           (nx_en),
      .nx_we           (nx_we),
      .nx_addr         (nx_addr),
      .nx_wdata        (nx_wdata),
      .nx_rdata        (nx_rdata),
      .pv_en           (pv_en),
      .pv_we           (pv_we),
      .pv_addr         (pv_addr),
      .pv_wdata        (pv_wdata),
      .pv_rdata        (pv_rdata)
   );

   // next links
   lrl_link_ram #(
      .DEPTH (SLOTS),
      .WIDTH (IDX_W)
   ) u_next_ram (
      .clock (clock),
      .en    (nx_en),
      .we    (nx_we),
      .addr  (nx_addr),
      .wdata (nx_wdata),
      .rdata (nx_rdata)
   );

   // previous links
   lrl_link_ram #(
      .DEPTH (SLOTS),
      .WIDTH (IDX_W)
   ) u_prev_ram (
      .clock (clock),
      .en    (pv_en),
      .we    (pv_we),
      .addr  (pv_addr),
      .wdata (pv_wdata),
      .rdata (pv_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done && rsp_free) begin
         rsp_ff   <= result;
         empty_ff <= (result.total == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ff.ok;
   assign rsp_popped_entry = rsp_ff.popped;
   assign rsp_head_entry   = rsp_ff.head;
   assign rsp_tail_entry   = rsp_ff.tail;
   assign rsp_entry_total  = rsp_ff.total;
   assign rsp_is_empty     = empty_ff;

endmodule

### rtl/lrl_link_ram.sv
// Single-port synchronous link memory, one access per cycle, registered read.
// Depends on lrl_pkg for default sizes.
module lrl_link_ram
   import lrl_pkg::*;
#(
   parameter int DEPTH = LRL_ENTRIES,
   parameter int WIDTH = ENTRY_W
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rd_ff <= mem[addr];
         end
      end
   end

   assign rdata = rd_ff;

endmodule

### rtl/lrl_seq.sv
// Request sequencer: head/tail/count, linked flags and link memory access steps.
// Depends on lrl_pkg; drives two lrl_link_ram instances through the top level.
module lrl_seq
   import lrl_pkg::*;
#(
   parameter int SLOTS = LRL_ENTRIES,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic [ENTRY_W-1:0] req_entry_index,
   input  logic               rsp_free,
   output logic               done,
   output result_type         result,
   output logic               nx_en,
   output logic               nx_we,
   output logic [IDX_W-1:0]   nx_addr,
   output logic [IDX_W-1:0]   nx_wdata,
   input  logic [IDX_W-1:0]   nx_rdata,
   output logic               pv_en,
   output logic               pv_we,
   output logic [IDX_W-1:0]   pv_addr,
   output logic [IDX_W-1:0]   pv_wdata,
   input  logic [IDX_W-1:0]   pv_rdata
);

   state_type          state_ff, state_in;
   action_type         act_ff, act_in;
   logic               valid_ff, valid_in;
   logic [IDX_W-1:0]   tgt_ff, tgt_in;
   logic [IDX_W-1:0]   lh_ff, lh_in;
   logic [IDX_W-1:0]   lt_ff, lt_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [TOTAL_W-1:0] cnt_ff, cnt_in;
   logic [SLOTS-1:0]   linked_ff, linked_in;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   pop_ff, pop_in;
   logic [IDX_W-1:0]   nh, nt;

   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE);

   // neighbor head/tail after removing tgt (prev in pv_rdata, next in nx_rdata)
   assign nh = (head_ff == tgt_ff) ? nx_rdata : head_ff;
   assign nt = (tail_ff == tgt_ff) ? pv_rdata : tail_ff;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      valid_in  = valid_ff;
      tgt_in    = tgt_ff;
      lh_in     = lh_ff;
      lt_in     = lt_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      linked_in = linked_ff;
      ok_in     = ok_ff;
      pop_in    = pop_ff;
      nx_en     = 1'b0;
      nx_we     = 1'b0;
      nx_addr   = '0;
      nx_wdata  = '0;
      pv_en     = 1'b0;
      pv_we     = 1'b0;
      pv_addr   = '0;
      pv_wdata  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = action_type'(req_action);
               valid_in = (int'(req_entry_index) < SLOTS);
               tgt_in   = req_entry_index[IDX_W-1:0];
               ok_in    = 1'b0;
               pop_in   = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (act_ff)
               ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
                  if (valid_ff && !linked_ff[tgt_ff]) begin
                     ok_in             = 1'b1;
                     linked_in[tgt_ff] = 1'b1;
                     cnt_in            = cnt_ff + 1'b1;
                     nx_en   = 1'b1;
                     nx_we   = 1'b1;
                     nx_addr = tgt_ff;
                     pv_en   = 1'b1;
                     pv_we   = 1'b1;
                     pv_addr = tgt_ff;
                     if (cnt_ff == '0) begin
                        // lone entry points at itself
                        nx_wdata = tgt_ff;
                        pv_wdata = tgt_ff;
                        head_in  = tgt_ff;
                        tail_in  = tgt_ff;
                     end else begin
                        nx_wdata = head_ff;
                        pv_wdata = tail_ff;
                        lh_in    = head_ff;
                        lt_in    = tail_ff;
                        if (act_ff == ACT_PUSH_HEAD) begin
                           head_in = tgt_ff;
                        end else begin
                           tail_in = tgt_ff;
                        end
                        state_in = S_LINK2;
                     end
                  end
               end
               ACT_POP_TAIL: begin
                  if (cnt_ff != '0) begin
                     ok_in  = 1'b1;
                     pop_in = tail_ff;
                     tgt_in = tail_ff;
                     if (cnt_ff == TOTAL_W'(1)) begin
                        linked_in[tail_ff] = 1'b0;
                        head_in = '0;
                        tail_in = '0;
                        cnt_in  = '0;
                     end else begin
                        nx_en    = 1'b1;
                        nx_addr  = tail_ff;
                        pv_en    = 1'b1;
                        pv_addr  = tail_ff;
                        state_in = S_READ;
                     end
                  end
               end
               ACT_UNLINK, ACT_MOVE_HEAD: begin
                  if (valid_ff && linked_ff[tgt_ff]) begin
                     ok_in = 1'b1;
                     if (cnt_ff == TOTAL_W'(1)) begin
                        // move of a lone entry changes nothing
                        if (act_ff == ACT_UNLINK) begin
                           linked_in[tgt_ff] = 1'b0;
                           head_in = '0;
                           tail_in = '0;
                           cnt_in  = '0;
                        end
                     end else begin
                        nx_en    = 1'b1;
                        nx_addr  = tgt_ff;
                        pv_en    = 1'b1;
                        pv_addr  = tgt_ff;
                        state_in = S_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            // bridge prev and next around tgt
            nx_en    = 1'b1;
            nx_we    = 1'b1;
            nx_addr  = pv_rdata;
            nx_wdata = nx_rdata;
            pv_en    = 1'b1;
            pv_we    = 1'b1;
            pv_addr  = nx_rdata;
            pv_wdata = pv_rdata;
            if (act_ff == ACT_MOVE_HEAD) begin
               lh_in    = nh;
               lt_in    = nt;
               state_in = S_MLINK;
            end else begin
               head_in           = nh;
               tail_in           = nt;
               linked_in[tgt_ff] = 1'b0;
               cnt_in            = cnt_ff - 1'b1;
               state_in          = S_DONE;
            end
         end
         S_MLINK: begin
            nx_en    = 1'b1;
            nx_we    = 1'b1;
            nx_addr  = tgt_ff;
            nx_wdata = lh_ff;
            pv_en    = 1'b1;
            pv_we    = 1'b1;
            pv_addr  = tgt_ff;
            pv_wdata = lt_ff;
            head_in  = tgt_ff;
            tail_in  = lt_ff;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            nx_en    = 1'b1;
            nx_we    = 1'b1;
            nx_addr  = lt_ff;
            nx_wdata = tgt_ff;
            pv_en    = 1'b1;
            pv_we    = 1'b1;
            pv_addr  = lh_ff;
            pv_wdata = tgt_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
         linked_ff <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
         linked_ff <= linked_in;
      end
      act_ff   <= act_in;
      valid_ff <= valid_in;
      tgt_ff   <= tgt_in;
      lh_ff    <= lh_in;
      lt_ff    <= lt_in;
      ok_ff    <= ok_in;
      pop_ff   <= pop_in;
   end

   assign result.ok     = ok_ff;
   assign result.popped = ENTRY_W'(pop_ff);
   assign result.head   = ENTRY_W'(head_ff);
   assign result.tail   = ENTRY_W'(tail_ff);
   assign result.total  = cnt_ff;

   a_count_matches_flags: assert property (@(posedge clock) disable iff (reset)
      $countones(linked_ff) == int'(cnt_ff))
      else $error("linked flag population differs from list count");

   a_empty_zero_ends: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with nonzero head or tail");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_EXEC))
      else $error("accepted request did not start execution");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_free) |=>
         (state_ff == S_DONE && $stable(head_ff) && $stable(cnt_ff)))
      else $error("finished request lost while response slot busy");

endmodule
